// ===== sv/plti_pkg.sv =====
// ----------------------------------------------------------------------------
// plti_pkg
// Shared constants, breakpoint table and inter-stage types for the
// piecewise-linear refraction index lookup.
// ----------------------------------------------------------------------------
package plti_pkg;

   localparam int ENTRIES    = 42;
   localparam int WAVE_BITS  = 20;
   localparam int INDEX_BITS = 16;
   localparam int SEG_BITS   = (ENTRIES > 2) ? $clog2(ENTRIES) : 1;
   localparam int PROD_BITS  = INDEX_BITS + WAVE_BITS;

   typedef logic [WAVE_BITS-1:0]  wave_type;
   typedef logic [INDEX_BITS-1:0] index_type;
   typedef logic [SEG_BITS-1:0]   seg_type;
   typedef logic [PROD_BITS-1:0]  prod_type;
   typedef logic [1:0]            flag_type;

   localparam flag_type FLAG_INSIDE = 2'd0;
   localparam flag_type FLAG_BELOW  = 2'd1;
   localparam flag_type FLAG_ABOVE  = 2'd2;

   // breakpoint wavelengths, 2^-16 um units
   localparam wave_type ROM_WAVE [ENTRIES] = '{
       3355,  3532,  3696,  3867,  4063,  4280,  4515,  4778,  5079,  5420,
       5806,  6246,  6770,  7386,  7740,  8126,  8552,  9031,  9562, 10158,
      10486, 10833, 11207, 11606, 12039, 12498, 13002, 13540, 14130, 14772,
      15349, 15598, 17105, 18055, 19117, 20316, 23213, 27086, 32499, 40626,
      54172, 81265
   };

   // real index part, 2^-14 units
   localparam index_type ROM_RE [ENTRIES] = '{
      10732, 10240, 10011, 10109, 10404, 11076, 12042, 13271, 14778, 16400,
      18203, 20431, 23216, 27148, 29934, 32768, 35422, 38109, 40829, 43434,
      44417, 45105, 45318, 45089, 44630, 43942, 42926, 41632, 40370, 39207,
      38191, 37323, 36602, 36012, 35504, 35078, 34390, 33849, 33440, 33128,
      32899, 32735
   };

   // extinction part, 2^-14 units
   localparam index_type ROM_IM [ENTRIES] = '{
       6881,  7881,  9175, 10600, 12173, 13779, 15335, 16876, 18186, 19333,
      20644, 22118, 23429, 24904, 25068, 24412, 23593, 21627, 19005, 15761,
      14189, 12288, 10027,  8077,  6226,  4473,  2851,  1671,   934,   475,
        180,   803,    20,     4,     0,     0,     0,     0,     0,     0,
          0,     0
   };

   typedef struct packed {
      wave_type wave;
      seg_type  seg;
      flag_type flag;
   } search_type;

   typedef struct packed {
      index_type lo_re;
      index_type hi_re;
      index_type lo_im;
      index_type hi_im;
      wave_type  dl;
      wave_type  dh;
      flag_type  flag;
   } lerp_type;

   typedef struct packed {
      prod_type num_re;
      prod_type num_im;
      wave_type den;
      flag_type flag;
   } quot_type;

endpackage

// ===== sv/plti_search.sv =====
// ----------------------------------------------------------------------------
// plti_search
// Two-stage segment search: compare against all breakpoints, then encode
// the segment number and the range flag.
// ----------------------------------------------------------------------------
module plti_search (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  plti_pkg::wave_type        in_wave,
   output logic                      out_valid,
   input  logic                      out_ready,
   output plti_pkg::search_type      out_data
);

   logic                              s1_v_ff;
   plti_pkg::wave_type                s1_wave_ff;
   logic [plti_pkg::ENTRIES-1:0]      s1_gt_ff;
   logic [plti_pkg::ENTRIES-1:0]      s1_gt_in;
   logic                              s1_lt_ff;
   logic                              s1_rdy;

   logic                              s2_v_ff;
   plti_pkg::search_type              s2_data_ff;
   plti_pkg::search_type              s2_data_in;
   logic                              s2_rdy;

   assign s2_rdy   = !s2_v_ff || out_ready;
   assign s1_rdy   = !s1_v_ff || s2_rdy;
   assign in_ready = s1_rdy;

   always_comb begin
      for (int j = 0; j < plti_pkg::ENTRIES; j++) begin
         s1_gt_in[j] = in_wave > plti_pkg::ROM_WAVE[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_rdy) begin
         s1_v_ff <= in_valid;
      end
      if (s1_rdy) begin
         s1_wave_ff <= in_wave;
         s1_gt_ff   <= s1_gt_in;
         s1_lt_ff   <= in_wave < plti_pkg::ROM_WAVE[0];
      end
   end

   // table is increasing, so the highest breakpoint below x marks the segment
   always_comb begin
      s2_data_in.wave = s1_wave_ff;
      s2_data_in.seg  = '0;
      for (int j = 1; j < plti_pkg::ENTRIES - 1; j++) begin
         if (s1_gt_ff[j]) begin
            s2_data_in.seg = plti_pkg::SEG_BITS'(j);
         end
      end
      if (s1_lt_ff) begin
         s2_data_in.flag = plti_pkg::FLAG_BELOW;
      end else if (s1_gt_ff[plti_pkg::ENTRIES-1]) begin
         s2_data_in.flag = plti_pkg::FLAG_ABOVE;
      end else begin
         s2_data_in.flag = plti_pkg::FLAG_INSIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s2_rdy) begin
         s2_v_ff <= s1_v_ff;
      end
      if (s2_rdy) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign out_valid = s2_v_ff;
   assign out_data  = s2_data_ff;

endmodule

// ===== sv/plti_fetch.sv =====
// ----------------------------------------------------------------------------
// plti_fetch
// Reads both segment end rows from the table and forms the two distances.
// Clamped items and zero-length segments become a blend with weight one.
// ----------------------------------------------------------------------------
module plti_fetch (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  plti_pkg::search_type      in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output plti_pkg::lerp_type        out_data
);

   logic                  v_ff;
   plti_pkg::lerp_type    data_ff;
   plti_pkg::lerp_type    data_in;
   plti_pkg::seg_type     idx_lo;
   plti_pkg::seg_type     idx_hi;
   plti_pkg::wave_type    w_lo;
   plti_pkg::wave_type    w_hi;
   logic                  rdy;

   assign rdy      = !v_ff || out_ready;
   assign in_ready = rdy;

   always_comb begin
      idx_lo = in_data.seg;
      idx_hi = in_data.seg + 1'b1;
      w_lo   = plti_pkg::ROM_WAVE[idx_lo];
      w_hi   = plti_pkg::ROM_WAVE[idx_hi];
      data_in.flag  = in_data.flag;
      data_in.lo_re = plti_pkg::ROM_RE[idx_lo];
      data_in.hi_re = plti_pkg::ROM_RE[idx_hi];
      data_in.lo_im = plti_pkg::ROM_IM[idx_lo];
      data_in.hi_im = plti_pkg::ROM_IM[idx_hi];
      data_in.dl    = in_data.wave - w_lo;
      data_in.dh    = w_hi - in_data.wave;
      case (in_data.flag)
         plti_pkg::FLAG_BELOW: begin
            data_in.lo_re = plti_pkg::ROM_RE[0];
            data_in.lo_im = plti_pkg::ROM_IM[0];
            data_in.dl    = '0;
            data_in.dh    = plti_pkg::WAVE_BITS'(1);
         end
         plti_pkg::FLAG_ABOVE: begin
            data_in.lo_re = plti_pkg::ROM_RE[plti_pkg::ENTRIES-1];
            data_in.lo_im = plti_pkg::ROM_IM[plti_pkg::ENTRIES-1];
            data_in.dl    = '0;
            data_in.dh    = plti_pkg::WAVE_BITS'(1);
         end
         default: begin
            // zero-length segment returns the lower row
            if (w_lo == w_hi) begin
               data_in.dl = '0;
               data_in.dh = plti_pkg::WAVE_BITS'(1);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (rdy) begin
         v_ff <= in_valid;
      end
      if (rdy) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = v_ff;
   assign out_data  = data_ff;

endmodule

// ===== sv/plti_mac.sv =====
// ----------------------------------------------------------------------------
// plti_mac
// Weighted sums for both index parts: products and the segment length in
// one stage, sums in the next.
// ----------------------------------------------------------------------------
module plti_mac (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  plti_pkg::lerp_type        in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output plti_pkg::quot_type        out_data
);

   logic                  m_v_ff;
   plti_pkg::prod_type    p_lo_re_ff;
   plti_pkg::prod_type    p_hi_re_ff;
   plti_pkg::prod_type    p_lo_im_ff;
   plti_pkg::prod_type    p_hi_im_ff;
   plti_pkg::wave_type    m_den_ff;
   plti_pkg::flag_type    m_flag_ff;
   logic                  m_rdy;

   logic                  a_v_ff;
   plti_pkg::quot_type    a_data_ff;
   plti_pkg::quot_type    a_data_in;
   logic                  a_rdy;

   assign a_rdy    = !a_v_ff || out_ready;
   assign m_rdy    = !m_v_ff || a_rdy;
   assign in_ready = m_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff <= 1'b0;
      end else if (m_rdy) begin
         m_v_ff <= in_valid;
      end
      if (m_rdy) begin
         p_lo_re_ff <= plti_pkg::prod_type'(in_data.lo_re) * plti_pkg::prod_type'(in_data.dh);
         p_hi_re_ff <= plti_pkg::prod_type'(in_data.hi_re) * plti_pkg::prod_type'(in_data.dl);
         p_lo_im_ff <= plti_pkg::prod_type'(in_data.lo_im) * plti_pkg::prod_type'(in_data.dh);
         p_hi_im_ff <= plti_pkg::prod_type'(in_data.hi_im) * plti_pkg::prod_type'(in_data.dl);
         m_den_ff   <= plti_pkg::wave_type'(in_data.dl + in_data.dh);
         m_flag_ff  <= in_data.flag;
      end
   end

   // sums stay below den * 2^INDEX_BITS, so they fit the product width
   always_comb begin
      a_data_in.num_re = plti_pkg::prod_type'(p_lo_re_ff + p_hi_re_ff);
      a_data_in.num_im = plti_pkg::prod_type'(p_lo_im_ff + p_hi_im_ff);
      a_data_in.den    = m_den_ff;
      a_data_in.flag   = m_flag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (a_rdy) begin
         a_v_ff <= m_v_ff;
      end
      if (a_rdy) begin
         a_data_ff <= a_data_in;
      end
   end

   assign out_valid = a_v_ff;
   assign out_data  = a_data_ff;

endmodule

// ===== sv/plti_div.sv =====
// ----------------------------------------------------------------------------
// plti_div
// Pipelined restoring divider, one quotient bit per stage, for both index
// parts against the shared segment length.
// ----------------------------------------------------------------------------
module plti_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  plti_pkg::quot_type        in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output plti_pkg::index_type       out_re,
   output plti_pkg::index_type       out_im,
   output plti_pkg::flag_type        out_flag
);

   localparam int STAGES = plti_pkg::INDEX_BITS;

   logic                  v_ff      [STAGES];
   plti_pkg::wave_type    rem_re_ff [STAGES];
   plti_pkg::wave_type    rem_im_ff [STAGES];
   plti_pkg::index_type   sh_re_ff  [STAGES];
   plti_pkg::index_type   sh_im_ff  [STAGES];
   plti_pkg::wave_type    den_ff    [STAGES];
   plti_pkg::flag_type    flag_ff   [STAGES];
   logic                  rdy       [STAGES];

   logic                  src_v      [STAGES];
   plti_pkg::wave_type    src_rem_re [STAGES];
   plti_pkg::wave_type    src_rem_im [STAGES];
   plti_pkg::index_type   src_sh_re  [STAGES];
   plti_pkg::index_type   src_sh_im  [STAGES];
   plti_pkg::wave_type    src_den    [STAGES];
   plti_pkg::flag_type    src_flag   [STAGES];

   assign in_ready = rdy[0];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic [plti_pkg::WAVE_BITS:0] trial_re;
      logic [plti_pkg::WAVE_BITS:0] trial_im;
      logic                         ge_re;
      logic                         ge_im;

      if (s == 0) begin : g_first
         // quotient fits INDEX_BITS, so the upper part starts below den
         assign src_v[s]      = in_valid;
         assign src_rem_re[s] = in_data.num_re[plti_pkg::PROD_BITS-1:plti_pkg::INDEX_BITS];
         assign src_rem_im[s] = in_data.num_im[plti_pkg::PROD_BITS-1:plti_pkg::INDEX_BITS];
         assign src_sh_re[s]  = in_data.num_re[plti_pkg::INDEX_BITS-1:0];
         assign src_sh_im[s]  = in_data.num_im[plti_pkg::INDEX_BITS-1:0];
         assign src_den[s]    = in_data.den;
         assign src_flag[s]   = in_data.flag;
      end else begin : g_next
         assign src_v[s]      = v_ff[s-1];
         assign src_rem_re[s] = rem_re_ff[s-1];
         assign src_rem_im[s] = rem_im_ff[s-1];
         assign src_sh_re[s]  = sh_re_ff[s-1];
         assign src_sh_im[s]  = sh_im_ff[s-1];
         assign src_den[s]    = den_ff[s-1];
         assign src_flag[s]   = flag_ff[s-1];
      end

      if (s == STAGES - 1) begin : g_last_rdy
         assign rdy[s] = !v_ff[s] || out_ready;
      end else begin : g_mid_rdy
         assign rdy[s] = !v_ff[s] || rdy[s+1];
      end

      assign trial_re = {src_rem_re[s], src_sh_re[s][plti_pkg::INDEX_BITS-1]};
      assign trial_im = {src_rem_im[s], src_sh_im[s][plti_pkg::INDEX_BITS-1]};
      assign ge_re    = trial_re >= {1'b0, src_den[s]};
      assign ge_im    = trial_im >= {1'b0, src_den[s]};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (rdy[s]) begin
            v_ff[s] <= src_v[s];
         end
         if (rdy[s]) begin
            // remainder stays below den, so the top bit drops
            rem_re_ff[s] <= ge_re ? plti_pkg::wave_type'(trial_re - {1'b0, src_den[s]})
                                  : plti_pkg::wave_type'(trial_re);
            rem_im_ff[s] <= ge_im ? plti_pkg::wave_type'(trial_im - {1'b0, src_den[s]})
                                  : plti_pkg::wave_type'(trial_im);
            sh_re_ff[s]  <= {src_sh_re[s][plti_pkg::INDEX_BITS-2:0], ge_re};
            sh_im_ff[s]  <= {src_sh_im[s][plti_pkg::INDEX_BITS-2:0], ge_im};
            den_ff[s]    <= src_den[s];
            flag_ff[s]   <= src_flag[s];
         end
      end
   end

   assign out_valid = v_ff[STAGES-1];
   assign out_re    = sh_re_ff[STAGES-1];
   assign out_im    = sh_im_ff[STAGES-1];
   assign out_flag  = flag_ff[STAGES-1];

endmodule

// ===== sv/piecewise_linear_table_interp_top.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp_top
// Pipeline: 2 search, 1 fetch, 2 multiply-add and 16 divider stages (one
// quotient bit per stage) lie between req acceptance and rsp_valid.
// Throughput: one item per cycle unless rsp_ready stalls; each stage holds its item while stalled.
// Reset: synchronous, clears all stage valid bits; the table is constant.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interp_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  plti_pkg::wave_type        req_wavelength,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output plti_pkg::index_type       rsp_index_real,
   output plti_pkg::index_type       rsp_index_imag,
   output plti_pkg::flag_type        rsp_range_flag
);

   logic                    srch_valid;
   logic                    srch_ready;
   plti_pkg::search_type    srch_data;

   logic                    lerp_valid;
   logic                    lerp_ready;
   plti_pkg::lerp_type      lerp_data;

   logic                    quot_valid;
   logic                    quot_ready;
   plti_pkg::quot_type      quot_data;

   plti_search u_search (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_wave   (req_wavelength),
      .out_valid (srch_valid),
      .out_ready (srch_ready),
      .out_data  (srch_data)
   );

   plti_fetch u_fetch (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (srch_valid),
      .in_ready  (srch_ready),
      .in_data   (srch_data),
      .out_valid (lerp_valid),
      .out_ready (lerp_ready),
      .out_data  (lerp_data)
   );

   plti_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (lerp_valid),
      .in_ready  (lerp_ready),
      .in_data   (lerp_data),
      .out_valid (quot_valid),
      .out_ready (quot_ready),
      .out_data  (quot_data)
   );

   plti_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (quot_valid),
      .in_ready  (quot_ready),
      .in_data   (quot_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_re    (rsp_index_real),
      .out_im    (rsp_index_imag),
      .out_flag  (rsp_range_flag)
   );

endmodule
